// File: design/learning_switch_forward_core_macros.svh
// Assertion helpers; clk_i and rst_ni are taken from the enclosing module.
`ifndef LEARNING_SWITCH_FORWARD_CORE_MACROS_SVH
`define LEARNING_SWITCH_FORWARD_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LSF_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |-> (b)) \
    else $error("lsf: same-cycle check failed");
`define LSF_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (a) |=> (b)) \
    else $error("lsf: next-cycle check failed");
`else
`define LSF_ASSERT_IMP(lbl, a, b)
`define LSF_ASSERT_NXT(lbl, a, b)
`endif
`endif

// File: design/lsf_pkg.sv
package lsf_pkg;

  localparam int unsigned HOST_W    = 6;
  localparam int unsigned PORT_W    = 4;
  localparam int unsigned AGE_W     = 16;
  localparam int unsigned SPAN_W    = 5;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned FLOOD_CAP = 16;

  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_AGE_LIMIT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PORTS_IN_USE = 1'b1;

  localparam logic [AGE_W-1:0]  AGE_LIMIT_RST    = 16'd1000;
  localparam logic [SPAN_W-1:0] PORTS_IN_USE_RST = 5'd16;

  typedef struct packed {
    logic              is_tick;
    logic [HOST_W-1:0] src;
    logic              src_ok;
    logic [HOST_W-1:0] dst;
    logic              dst_ok;
    logic [PORT_W-1:0] arriv;
  } lsf_cmd_t;

  typedef struct packed {
    logic              valid;
    logic [AGE_W-1:0]  age;
    logic [PORT_W-1:0] port;
  } lsf_entry_t;

endpackage

// File: design/lsf_ram.sv
module lsf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/lsf_queue.sv
module lsf_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  lsf_pkg::lsf_cmd_t cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output lsf_pkg::lsf_cmd_t cmd_o
);
  import lsf_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  lsf_cmd_t         slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_FULL);
  assign valid_o = (count_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_d = CNT_W'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = CNT_W'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: design/lsf_front.sv
module lsf_front #(
  parameter int unsigned NUM_HOSTS = 64
) (
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [15:0]       s_tdata_i,
  input  logic [0:0]        s_tuser_i,
  input  logic              init_done_i,
  input  logic              q_full_i,
  output logic              push_o,
  output lsf_pkg::lsf_cmd_t cmd_o
);
  import lsf_pkg::*;

  logic [HOST_W-1:0] src, dst;

  assign src = s_tdata_i[5:0];
  assign dst = s_tdata_i[11:6];

  assign s_tready_o = init_done_i && !q_full_i;
  assign push_o     = s_tvalid_i && s_tready_o;

  always_comb begin
    cmd_o.is_tick = (s_tuser_i[0] == REQ_TICK);
    cmd_o.src     = src;
    cmd_o.src_ok  = (32'(src) < NUM_HOSTS);
    cmd_o.dst     = dst;
    cmd_o.dst_ok  = (32'(dst) < NUM_HOSTS);
    cmd_o.arriv   = s_tdata_i[15:12];
  end

endmodule

// File: design/lsf_back.sv
module lsf_back #(
  parameter int unsigned NUM_HOSTS   = 64,
  parameter int unsigned FLOOD_PORTS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [lsf_pkg::AGE_W-1:0]  age_limit_i,
  input  logic [lsf_pkg::SPAN_W-1:0] ports_in_use_i,
  input  logic                       q_valid_i,
  input  lsf_pkg::lsf_cmd_t          q_cmd_i,
  output logic                       q_pop_o,
  output logic                       init_done_o,
  output logic                       m_tvalid_o,
  input  logic                       m_tready_i,
  output logic [lsf_pkg::PORT_W-1:0] m_port_o,
  output logic                       m_flooded_o,
  output logic                       m_last_o
);
  import lsf_pkg::*;

  localparam int unsigned AW      = $clog2(NUM_HOSTS);
  localparam int unsigned ENTRY_W = $bits(lsf_entry_t);
  localparam logic [AW-1:0]     HOST_LAST = AW'(NUM_HOSTS - 1);
  localparam logic [SPAN_W-1:0] SPAN_MAX  = SPAN_W'(FLOOD_PORTS);

  localparam logic [2:0] S_INIT     = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_SRC      = 3'd2;
  localparam logic [2:0] S_DST_RD   = 3'd3;
  localparam logic [2:0] S_DST      = 3'd4;
  localparam logic [2:0] S_FLOOD    = 3'd5;
  localparam logic [2:0] S_TICK     = 3'd6;
  localparam logic [2:0] S_TICK_END = 3'd7;

  function automatic lsf_entry_t age_entry(lsf_entry_t e);
    lsf_entry_t r;
    r = e;
    if (e.valid) begin
      if (e.age <= AGE_W'(1)) begin
        r.valid = 1'b0;
        r.age   = '0;
      end else begin
        r.age = AGE_W'(e.age - 1'b1);
      end
    end
    return r;
  endfunction

  logic [2:0]        state_q, state_d;
  lsf_cmd_t          cmd_q, cmd_d;
  logic [AW-1:0]     cnt_q, cnt_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     waddr_q, waddr_d;
  logic [SPAN_W-1:0] p_q, p_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  lsf_entry_t        ram_wdata, ram_rdata;

  logic              out_valid_q;
  logic [PORT_W-1:0] out_port_q;
  logic              out_flood_q, out_last_q;
  logic              out_free, load_out;
  logic [PORT_W-1:0] ld_port;
  logic              ld_flood, ld_last;

  logic [SPAN_W-1:0] span, arriv_w, last_p;

  lsf_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(NUM_HOSTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign out_free    = !out_valid_q || m_tready_i;
  assign init_done_o = (state_q != S_INIT);

  assign span    = (ports_in_use_i < SPAN_MAX) ? ports_in_use_i : SPAN_MAX;
  assign arriv_w = SPAN_W'(cmd_q.arriv);
  assign last_p  = (SPAN_W'(arriv_w + 1'b1) == span) ? SPAN_W'(span - 2'd2)
                                                      : SPAN_W'(span - 1'b1);

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    cnt_d     = cnt_q;
    pend_d    = pend_q;
    waddr_d   = waddr_q;
    p_d       = p_q;
    q_pop_o   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    load_out  = 1'b0;
    ld_port   = '0;
    ld_flood  = 1'b0;
    ld_last   = 1'b0;
    unique case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q;
        cnt_d     = AW'(cnt_q + 1'b1);
        if (cnt_q == HOST_LAST) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          if (q_cmd_i.is_tick) begin
            cnt_d   = '0;
            pend_d  = 1'b0;
            state_d = S_TICK;
          end else if (q_cmd_i.src_ok) begin
            ram_re    = 1'b1;
            ram_raddr = AW'(q_cmd_i.src);
            state_d   = S_SRC;
          end else begin
            state_d = S_DST_RD;
          end
        end
      end
      S_SRC: begin
        // learn on a miss, keep the old port on a hit, refresh age either way
        ram_we          = 1'b1;
        ram_waddr       = AW'(cmd_q.src);
        ram_wdata.valid = 1'b1;
        ram_wdata.age   = age_limit_i;
        ram_wdata.port  = ram_rdata.valid ? ram_rdata.port : cmd_q.arriv;
        state_d         = S_DST_RD;
      end
      S_DST_RD: begin
        if (cmd_q.dst_ok) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(cmd_q.dst);
          state_d   = S_DST;
        end else begin
          p_d     = '0;
          state_d = S_FLOOD;
        end
      end
      S_DST: begin
        if (ram_rdata.valid) begin
          if (ram_rdata.port == cmd_q.arriv) begin
            state_d = S_IDLE;
          end else if (out_free) begin
            load_out = 1'b1;
            ld_port  = ram_rdata.port;
            ld_last  = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          p_d     = '0;
          state_d = S_FLOOD;
        end
      end
      S_FLOOD: begin
        if (p_q >= span) begin
          state_d = S_IDLE;
        end else if (p_q == arriv_w) begin
          p_d = SPAN_W'(p_q + 1'b1);
        end else if (out_free) begin
          load_out = 1'b1;
          ld_port  = PORT_W'(p_q);
          ld_flood = 1'b1;
          ld_last  = (p_q == last_p);
          p_d      = SPAN_W'(p_q + 1'b1);
          if (p_q == last_p) begin
            state_d = S_IDLE;
          end
        end
      end
      S_TICK: begin
        ram_re    = 1'b1;
        ram_raddr = cnt_q;
        pend_d    = 1'b1;
        waddr_d   = cnt_q;
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = waddr_q;
          ram_wdata = age_entry(ram_rdata);
        end
        cnt_d = AW'(cnt_q + 1'b1);
        if (cnt_q == HOST_LAST) begin
          cnt_d   = '0;
          state_d = S_TICK_END;
        end
      end
      S_TICK_END: begin
        ram_we    = 1'b1;
        ram_waddr = waddr_q;
        ram_wdata = age_entry(ram_rdata);
        pend_d    = 1'b0;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    waddr_q <= waddr_d;
    p_q     <= p_d;
    if (load_out) begin
      out_port_q  <= ld_port;
      out_flood_q <= ld_flood;
      out_last_q  <= ld_last;
    end
  end

  assign m_tvalid_o  = out_valid_q;
  assign m_port_o    = out_port_q;
  assign m_flooded_o = out_flood_q;
  assign m_last_o    = out_last_q;

endmodule

// File: design/learning_switch_forward_core.sv
// Learning bridge forwarding core with address aging. Each input beat is a
// frame or an aging tick; beats are decoded into a two-deep command queue and
// executed by a sequencer around a single table RAM (one read and one write
// port, NUM_HOSTS entries). A frame learns or refreshes its source entry
// (skipped when src_host is out of range), then is forwarded, filtered or,
// on a dst_host miss or out-of-range dst_host, flooded to each port in the
// flood range but the arrival port, in ascending order, holding while the
// output is stalled. A tick ages every table entry through the RAM ports.
// After reset the table is cleared in a pass during which no input beat is
// accepted; configuration writes are taken at any time, cfg_ready_o is always high.
`include "learning_switch_forward_core_macros.svh"

module learning_switch_forward_core #(
  parameter int unsigned NUM_HOSTS = 64,
  parameter int unsigned NUM_PORTS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lsf_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                   cfg_data_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [15:0]                   s_axis_tdata,  // src_host, dst_host, arrival_port
  input  logic [0:0]                    s_axis_tuser,  // req_type
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,  // out_port, zero pad
  output logic [0:0]                    m_axis_tuser,  // flooded
  output logic                          m_axis_tlast
);
  import lsf_pkg::*;

  localparam int unsigned FLOOD_PORTS = (NUM_PORTS < FLOOD_CAP) ? NUM_PORTS : FLOOD_CAP;
  localparam logic [SPAN_W-1:0] FLOOD_LIM = SPAN_W'(FLOOD_PORTS);

  logic [AGE_W-1:0]  age_limit_q;
  logic [SPAN_W-1:0] ports_in_use_q;
  logic              init_done;
  logic              q_full, q_valid, q_pop, push;
  lsf_cmd_t          push_cmd, head_cmd;
  logic [PORT_W-1:0] out_port;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      age_limit_q    <= AGE_LIMIT_RST;
      ports_in_use_q <= PORTS_IN_USE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_AGE_LIMIT:    age_limit_q    <= cfg_data_i;
        REG_PORTS_IN_USE: ports_in_use_q <= cfg_data_i[SPAN_W-1:0];
        default:          ;
      endcase
    end
  end

  lsf_front #(
    .NUM_HOSTS(NUM_HOSTS)
  ) u_front (
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .init_done_i(init_done),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  lsf_queue #(
    .DEPTH(2)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .cmd_o  (head_cmd)
  );

  lsf_back #(
    .NUM_HOSTS  (NUM_HOSTS),
    .FLOOD_PORTS(FLOOD_PORTS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .age_limit_i   (age_limit_q),
    .ports_in_use_i(ports_in_use_q),
    .q_valid_i     (q_valid),
    .q_cmd_i       (head_cmd),
    .q_pop_o       (q_pop),
    .init_done_o   (init_done),
    .m_tvalid_o    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_port_o      (out_port),
    .m_flooded_o   (m_axis_tuser[0]),
    .m_last_o      (m_axis_tlast)
  );

  assign m_axis_tdata = 8'(out_port);

  `LSF_ASSERT_IMP(a_no_accept_in_clear, s_axis_tvalid && s_axis_tready, init_done)
  `LSF_ASSERT_NXT(a_clear_done_sticks, init_done, init_done)
  `LSF_ASSERT_IMP(a_unicast_is_last, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast)
  `LSF_ASSERT_IMP(a_flood_port_range, m_axis_tvalid && m_axis_tuser[0], SPAN_W'(out_port) < FLOOD_LIM)

endmodule
